[rtl/retiring_range_successor_select_assert.svh]
// Assertion macros for the checker file of the successor selector.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef RETIRING_RANGE_SUCCESSOR_SELECT_ASSERT_SVH
`define RETIRING_RANGE_SUCCESSOR_SELECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRSS_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RRSS_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rrss_pkg.sv]
// Package for the retiring-range successor selector.
// Holds the table size, lease entry type, codes and control structs; no dependencies.
`timescale 1ns / 1ps

package rrss_pkg;

    // Table geometry.
    localparam int LEASE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(LEASE_ENTRIES);

    // Field widths fixed by the interface.
    localparam int SIZE_W   = 48;
    localparam int OFFSET_W = 48;
    localparam int REL_W    = 32;
    localparam int FLAG_W   = 5;
    localparam int ALIGN_W  = 6;
    localparam int REQ_W    = 32;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 192;
    localparam int M_TDATA_W = 184;

    // Flag bit positions inside a lease entry.
    localparam int F_RETIRE = 0;
    localparam int F_PUB    = 1;
    localparam int F_EXP    = 2;
    localparam int F_OWN    = 3;
    localparam int F_CLAIM  = 4;

    // Operation codes.
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_RESERVE = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NONE   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Configuration register byte-address bit that selects the register.
    localparam logic REG_MIN_ALIGN = 1'b0;

    typedef struct packed {
        logic [SIZE_W-1:0]   size;
        logic [OFFSET_W-1:0] offset;
        logic [REL_W-1:0]    rel;
        logic [FLAG_W-1:0]   flags;
    } lease_t;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             shift;
        logic             write;
        logic             release_own;
        logic             claim;
        logic [IDX_W-1:0] idx;
        lease_t           wr_entry;
    } cell_ctrl_t;

    // Controls from the sequencer to the candidate picker at the ring head.
    typedef struct packed {
        logic               start;
        logic               step;
        logic [IDX_W-1:0]   idx;
        logic [SIZE_W-1:0]  bytes;
        logic [ALIGN_W-1:0] align_log2;
    } pick_ctrl_t;

endpackage

[rtl/rrss_cell.sv]
// One lease cell of the rotating table ring.
// Depends on rrss_pkg for the entry type and the broadcast control struct.
`timescale 1ns / 1ps

module rrss_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [rrss_pkg::IDX_W-1:0] slot,
    input  rrss_pkg::cell_ctrl_t      ctrl,
    input  rrss_pkg::lease_t          shift_in,
    output rrss_pkg::lease_t          entry
);

    logic [rrss_pkg::SIZE_W-1:0]   size_reg;
    logic [rrss_pkg::OFFSET_W-1:0] offset_reg;
    logic [rrss_pkg::REL_W-1:0]    rel_reg;
    logic [rrss_pkg::FLAG_W-1:0]   flags_reg;
    logic                          hit;

    // The broadcast index addresses this cell only while the ring is at home.
    assign hit = (ctrl.idx == slot);

    // Flags reset to zero, so an unwritten entry never qualifies.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            flags_reg <= shift_in.flags;
        end
        else if (hit)
        begin
            if (ctrl.write)
            begin
                flags_reg <= ctrl.wr_entry.flags & ~(rrss_pkg::FLAG_W'(1) << rrss_pkg::F_CLAIM);
            end
            else if (ctrl.release_own)
            begin
                flags_reg[rrss_pkg::F_OWN] <= 1'b0;
            end
            else if (ctrl.claim)
            begin
                flags_reg[rrss_pkg::F_CLAIM] <= 1'b1;
            end
        end
    end

    // Lease data needs no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            size_reg   <= shift_in.size;
            offset_reg <= shift_in.offset;
            rel_reg    <= shift_in.rel;
        end
        else if (hit && ctrl.write)
        begin
            size_reg   <= ctrl.wr_entry.size;
            offset_reg <= ctrl.wr_entry.offset;
            rel_reg    <= ctrl.wr_entry.rel;
        end
    end

    assign entry.size   = size_reg;
    assign entry.offset = offset_reg;
    assign entry.rel    = rel_reg;
    assign entry.flags  = flags_reg;

endmodule

[rtl/rrss_pick.sv]
// Candidate picker at the head of the lease ring: qualifies and ranks one entry per cycle while stepped.
// Depends on rrss_pkg for the entry type and its control struct.
`timescale 1ns / 1ps

module rrss_pick (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrss_pkg::pick_ctrl_t          ctrl,
    input  logic [rrss_pkg::ALIGN_W-1:0]  min_align_log2,
    input  rrss_pkg::lease_t              head,
    output logic                          found,
    output logic [rrss_pkg::IDX_W-1:0]    best_idx,
    output rrss_pkg::lease_t              best
);

    logic                            found_reg;
    logic [rrss_pkg::IDX_W-1:0]      best_idx_reg;
    rrss_pkg::lease_t                best_reg;
    logic [rrss_pkg::SIZE_W-1:0]     bytes_reg;
    logic [rrss_pkg::OFFSET_W-1:0]   amask_reg;
    logic [rrss_pkg::OFFSET_W-1:0]   amask_next;
    logic [rrss_pkg::ALIGN_W-1:0]    align_eff;
    logic                            eligible;
    logic                            ahead;
    logic                            take;

    // Effective alignment is the larger of request and minimum; 48 or more masks all bits.
    always_comb
    begin
        align_eff = (ctrl.align_log2 < min_align_log2) ? min_align_log2 : ctrl.align_log2;
        if (align_eff >= rrss_pkg::ALIGN_W'(rrss_pkg::OFFSET_W))
        begin
            amask_next = '1;
        end
        else
        begin
            amask_next = (rrss_pkg::OFFSET_W'(1) << align_eff) - rrss_pkg::OFFSET_W'(1);
        end
    end

    // Qualification of the entry now at the ring head.
    assign eligible = head.flags[rrss_pkg::F_OWN] && head.flags[rrss_pkg::F_RETIRE]
                   && !head.flags[rrss_pkg::F_CLAIM]
                   && (head.flags[rrss_pkg::F_PUB] || head.flags[rrss_pkg::F_EXP])
                   && (head.size >= bytes_reg)
                   && ((head.offset & amask_reg) == '0);

    // Ranking: published event, then smaller size, earlier release, lower offset.
    always_comb
    begin
        priority if (head.flags[rrss_pkg::F_PUB] != best_reg.flags[rrss_pkg::F_PUB])
        begin
            ahead = head.flags[rrss_pkg::F_PUB];
        end
        else if (head.size != best_reg.size)
        begin
            ahead = (head.size < best_reg.size);
        end
        else if (head.rel != best_reg.rel)
        begin
            ahead = (head.rel < best_reg.rel);
        end
        else
        begin
            ahead = (head.offset < best_reg.offset);
        end
    end

    // A strict win keeps the lowest index on a full tie.
    assign take = ctrl.step && eligible && (!found_reg || ahead);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    // Request terms and the best entry so far.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            bytes_reg <= ctrl.bytes;
            amask_reg <= amask_next;
        end
        if (take)
        begin
            best_reg     <= head;
            best_idx_reg <= ctrl.idx;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best     = best_reg;

endmodule

[rtl/retiring_range_successor_select.sv]
// Top level of the retiring-range successor selector: sequencer, lease ring,
// picker, output register and configuration port. Depends on rrss_pkg, rrss_cell, rrss_pick.
//
// Usage:
//   Requests enter on the s_ stream (op in s_tuser, entry and reserve fields in s_tdata)
//   and every request yields exactly one result on the m_ stream (status in m_tuser).
//   A write or release request takes effect in its accept cycle and its result is
//   loaded from the finish state. A reserve request rotates the 16-cell lease ring
//   once past the picker, one entry per cycle, then writes back the claim and
//   totals and loads its result; a zero byte reserve skips the rotation and is
//   rejected. One request is in flight at a time: s_tready is low from acceptance
//   until the result is loaded into the output register.
//   A result waits in the output register while m_tready is low; a finished
//   request is held in the sequencer until that register frees, and s_tready stays
//   low meanwhile. The minimum alignment register is written over the APB port.
//   Reset clears all lease flags, the request counter, the reserved total, the
//   configuration register and the output valid.
`timescale 1ns / 1ps

module retiring_range_successor_select (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index[3:0], entry_size[51:4], entry_offset[99:52],
    // entry_release_order[131:100], entry_retire_pending[132],
    // entry_event_published[133], entry_event_expected[134], entry_owns_range[135],
    // request_bytes[183:136], request_align_log2[189:184], zero pad[191:190]
    input  logic [rrss_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [1:0]                      s_tuser,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // chosen_index[3:0], chosen_offset[51:4], chosen_size[99:52],
    // request_number[131:100], reserved_total_out[179:132], zero pad[183:180]
    output logic [rrss_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [1:0]                      m_tuser,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam int N = rrss_pkg::LEASE_ENTRIES;
    localparam logic [rrss_pkg::IDX_W-1:0] LAST_IDX = rrss_pkg::IDX_W'(N - 1);

    logic [1:0]                       state_reg, state_next;
    logic [rrss_pkg::IDX_W-1:0]       scan_cnt_reg;
    logic [rrss_pkg::ALIGN_W-1:0]     min_align_reg;
    logic [rrss_pkg::REQ_W-1:0]       req_count_reg;
    logic [rrss_pkg::SIZE_W-1:0]      total_reg;
    logic [rrss_pkg::SIZE_W-1:0]      total_next;
    logic [1:0]                       res_status_reg;
    logic                             reserve_reg;
    logic                             m_valid_reg;
    logic [rrss_pkg::M_TDATA_W-1:0]   m_data_reg;
    logic [1:0]                       m_status_reg;

    logic                             accept;
    logic                             out_free;
    logic                             finish;
    logic                             granted;
    logic                             in_range;
    logic [1:0]                       op;
    logic [3:0]                       entry_index;
    logic [rrss_pkg::SIZE_W-1:0]      request_bytes;
    logic [1:0]                       status_out;

    rrss_pkg::cell_ctrl_t             cell_ctrl;
    rrss_pkg::pick_ctrl_t             pick_ctrl;
    rrss_pkg::lease_t                 ring [N];
    logic                             found;
    logic [rrss_pkg::IDX_W-1:0]       best_idx;
    rrss_pkg::lease_t                 best;

    // Request field unpacking.
    assign op            = s_tuser;
    assign entry_index   = s_tdata[3:0];
    assign request_bytes = s_tdata[183:136];
    assign in_range      = (9'(entry_index) < 9'(N));

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign finish   = (state_reg == S_FINISH) && out_free;
    assign granted  = reserve_reg && found;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == rrss_pkg::OP_RESERVE && request_bytes != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == LAST_IDX)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SCAN)
            begin
                scan_cnt_reg <= (scan_cnt_reg == LAST_IDX) ? '0 : scan_cnt_reg + 1'b1;
            end
        end
    end

    // Pending status of the request in flight, decided at acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_status_reg <= rrss_pkg::ST_DONE;
            reserve_reg    <= 1'b0;
        end
        else if (accept)
        begin
            reserve_reg <= (op == rrss_pkg::OP_RESERVE) && (request_bytes != '0);
            if ((op == rrss_pkg::OP_WRITE || op == rrss_pkg::OP_RELEASE) && in_range)
            begin
                res_status_reg <= rrss_pkg::ST_DONE;
            end
            else if (op == rrss_pkg::OP_RESERVE && request_bytes != '0)
            begin
                res_status_reg <= rrss_pkg::ST_DONE;
            end
            else
            begin
                res_status_reg <= rrss_pkg::ST_REJECT;
            end
        end
    end

    // Broadcast controls for the cells.
    always_comb
    begin
        cell_ctrl.shift       = (state_reg == S_SCAN);
        cell_ctrl.write       = accept && (op == rrss_pkg::OP_WRITE) && in_range;
        cell_ctrl.release_own = accept && (op == rrss_pkg::OP_RELEASE) && in_range;
        cell_ctrl.claim       = finish && granted;
        cell_ctrl.idx         = (state_reg == S_FINISH) ? best_idx
                                                        : rrss_pkg::IDX_W'(entry_index);
        cell_ctrl.wr_entry.size   = s_tdata[51:4];
        cell_ctrl.wr_entry.offset = s_tdata[99:52];
        cell_ctrl.wr_entry.rel    = s_tdata[131:100];
        cell_ctrl.wr_entry.flags  = {1'b0, s_tdata[135:132]};
    end

    // Lease ring: each cell takes its upper neighbor's entry on a shift.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % N;

        rrss_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot     (rrss_pkg::IDX_W'(i)),
            .ctrl     (cell_ctrl),
            .shift_in (ring[NXT]),
            .entry    (ring[i])
        );
    end

    // Picker sees entry scan_cnt at the ring head on each scan cycle.
    always_comb
    begin
        pick_ctrl.start      = accept && (op == rrss_pkg::OP_RESERVE);
        pick_ctrl.step       = (state_reg == S_SCAN);
        pick_ctrl.idx        = scan_cnt_reg;
        pick_ctrl.bytes      = request_bytes;
        pick_ctrl.align_log2 = s_tdata[189:184];
    end

    rrss_pick u_pick (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (pick_ctrl),
        .min_align_log2 (min_align_reg),
        .head           (ring[0]),
        .found          (found),
        .best_idx       (best_idx),
        .best           (best)
    );

    // Write-back of the counter and running total on a grant.
    assign total_next = granted ? total_reg + best.size : total_reg;
    assign status_out = reserve_reg ? (found ? rrss_pkg::ST_DONE : rrss_pkg::ST_NONE)
                                    : res_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_count_reg <= '0;
            total_reg     <= '0;
        end
        else if (finish && granted)
        begin
            req_count_reg <= req_count_reg + 1'b1;
            total_reg     <= total_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            m_status_reg <= status_out;
            if (granted)
            begin
                m_data_reg <= {4'd0, total_next, req_count_reg, best.size, best.offset,
                               4'(best_idx)};
            end
            else
            begin
                m_data_reg <= {4'd0, total_next, 132'd0};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_align_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == rrss_pkg::REG_MIN_ALIGN)
        begin
            min_align_reg <= pwdata[rrss_pkg::ALIGN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rrss_pkg::REG_MIN_ALIGN) ? 32'(min_align_reg) : 32'd0;

endmodule

[rtl/rrss_checker.sv]
// Port-level checker for the successor selector, bound to the top level.
// Depends on rrss_pkg and the assertion macros in retiring_range_successor_select_assert.svh.
`timescale 1ns / 1ps
`include "retiring_range_successor_select_assert.svh"

module rrss_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rrss_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [1:0]                      m_tuser
);

    // A stalled result holds its payload.
    `RRSS_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Only the three defined status codes appear.
    `RRSS_ASSERT_IMP(a_status_code, clk, rst_n, m_tvalid, m_tuser == rrss_pkg::ST_DONE || m_tuser == rrss_pkg::ST_NONE || m_tuser == rrss_pkg::ST_REJECT, "undefined status code")

    // A result whose status is not done carries zero chosen fields.
    `RRSS_ASSERT_IMP(a_no_grant_zero, clk, rst_n, m_tvalid && m_tuser != rrss_pkg::ST_DONE, m_tdata[131:0] == '0, "chosen fields set without a reservation")

    // One request at a time: the block is busy right after an acceptance.
    `RRSS_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready, "request accepted while another is in flight")

endmodule

bind retiring_range_successor_select rrss_checker u_rrss_checker (.*);
